@@ sv/pcgmp_pkg.sv @@
`default_nettype none
// ============================================================================
// pcgmp_pkg
// Shared types, constants and helpers for the point cloud grid max projector.
// ============================================================================

package pcgmp_pkg;

    // Default geometry
    localparam int NUM_CHANNELS_DEF = 20;
    localparam int GRID_WIDTH_DEF   = 128;
    localparam int GRID_HEIGHT_DEF  = 128;

    // Field widths fixed by the item format
    localparam int FIX_W     = 32;
    localparam int CHAN_W    = 5;
    localparam int SCORE_W   = 8;
    localparam int FCOORD_W  = 7;
    localparam int PCT_W     = 7;
    localparam int STATUS_W  = 3;

    // Projection arithmetic widths
    localparam int PROD_W    = 2 * FIX_W;
    localparam int SUM_W     = PROD_W + 2;
    localparam int COORD_W   = SUM_W - FIX_W;

    // Configuration register file
    localparam int NUM_REGS   = 8;
    localparam int CFG_IDX_W  = 3;
    localparam logic [CFG_IDX_W-1:0] REG_ROW_X_COEF_X = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ROW_X_COEF_Y = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ROW_X_COEF_Z = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ROW_X_OFFSET = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_ROW_Y_COEF_X = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_ROW_Y_COEF_Y = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_ROW_Y_COEF_Z = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_ROW_Y_OFFSET = 3'd7;

    // Command queue between front and back
    localparam int QUEUE_DEPTH = 8;

    // v * 100 / 255 == (v * 3289700) >> 23 for every 8-bit v
    localparam int PCT_PROD_W = 30;
    localparam int PCT_SHIFT  = 23;
    localparam logic [PCT_PROD_W-1:0] PCT_SCALE = 30'd3289700;

    typedef enum logic
    {
        OP_INSERT = 1'b0,
        OP_READ   = 1'b1
    } op_t;

    typedef enum logic [STATUS_W-1:0]
    {
        ST_READ_DONE   = 3'd0,
        ST_RAISED      = 3'd1,
        ST_KEPT        = 3'd2,
        ST_OUTSIDE     = 3'd3,
        ST_BAD_CHANNEL = 3'd4
    } status_t;

    typedef enum logic [1:0]
    {
        CMD_READ,
        CMD_INSERT,
        CMD_OUTSIDE,
        CMD_BAD_CHANNEL
    } cmd_kind_t;

    typedef enum logic [1:0]
    {
        BK_CLEAR,
        BK_IDLE,
        BK_RESP
    } bk_state_t;

    // One classified command; the store address travels beside it
    typedef struct packed
    {
        cmd_kind_t           kind;
        logic [FCOORD_W-1:0] col;
        logic [FCOORD_W-1:0] row;
        logic [SCORE_W-1:0]  score;
    } cmd_t;

    // Item attributes carried along the projection pipeline
    typedef struct packed
    {
        op_t                 op;
        logic                ch_bad;
        logic [CHAN_W-1:0]   channel;
        logic [SCORE_W-1:0]  score;
        logic [FCOORD_W-1:0] read_col;
        logic [FCOORD_W-1:0] read_row;
    } item_info_t;

    // Back to front status
    typedef struct packed
    {
        logic clearing;
        logic pop;
    } back_status_t;

    function automatic logic [PCT_W-1:0] percent_of(input logic [SCORE_W-1:0] v);
        logic [PCT_PROD_W-1:0] prod;
        prod = PCT_PROD_W'(v) * PCT_SCALE;
        return prod[PCT_SHIFT +: PCT_W];
    endfunction

endpackage

`default_nettype wire

@@ sv/pcgmp_if.sv @@
`default_nettype none
// ============================================================================
// pcgmp_if
// Valid/ready channels for input items and result items.
// ============================================================================

interface pcgmp_item_if;
    logic                                valid;
    logic                                ready;
    logic                                operation;
    logic [pcgmp_pkg::CHAN_W-1:0]        channel;
    logic signed [pcgmp_pkg::FIX_W-1:0]  point_x;
    logic signed [pcgmp_pkg::FIX_W-1:0]  point_y;
    logic signed [pcgmp_pkg::FIX_W-1:0]  point_z;
    logic [pcgmp_pkg::SCORE_W-1:0]       score;
    logic [pcgmp_pkg::FCOORD_W-1:0]      read_col;
    logic [pcgmp_pkg::FCOORD_W-1:0]      read_row;

    modport source
    (
        output valid, operation, channel, point_x, point_y, point_z, score,
               read_col, read_row,
        input  ready
    );

    modport sink
    (
        input  valid, operation, channel, point_x, point_y, point_z, score,
               read_col, read_row,
        output ready
    );
endinterface

interface pcgmp_result_if;
    logic                             valid;
    logic                             ready;
    logic [pcgmp_pkg::STATUS_W-1:0]   status;
    logic [pcgmp_pkg::FCOORD_W-1:0]   cell_col;
    logic [pcgmp_pkg::FCOORD_W-1:0]   cell_row;
    logic [pcgmp_pkg::PCT_W-1:0]      percent;

    modport source
    (
        output valid, status, cell_col, cell_row, percent,
        input  ready
    );

    modport sink
    (
        input  valid, status, cell_col, cell_row, percent,
        output ready
    );
endinterface

`default_nettype wire

@@ sv/point_cloud_grid_max_projector_top.sv @@
`default_nettype none
// ============================================================================
// point_cloud_grid_max_projector_top
// Per-channel 2D max-confidence grid fed by projected sensor points.
// ============================================================================
//
// After reset the block sweeps the confidence store to zero, one cell per
// cycle, over all NUM_CHANNELS * GRID_HEIGHT * GRID_WIDTH cells (327680 at the
// default sizes); item.ready stays low during the sweep, while configuration
// writes are taken at any time. Each item yields exactly one result, in order.
// An item passes through the projection front (one multiply stage, two add
// stages, a truncate stage, then classification into the command queue) and
// the store back, which reads the cell through the registered read port of the
// store and writes a raised score back on the next cycle. That read-then-write
// on the single store paces the back: it takes a command only once the previous
// one has left its response state. The eight-entry queue lets the front keep
// accepting while a result waits in the output register; the front reserves a
// queue slot for each item it accepts, so ready drops when eight items are
// between acceptance and execution. Write configuration only while idle.

module point_cloud_grid_max_projector_top #(
    parameter int NUM_CHANNELS = pcgmp_pkg::NUM_CHANNELS_DEF,
    parameter int GRID_WIDTH   = pcgmp_pkg::GRID_WIDTH_DEF,
    parameter int GRID_HEIGHT  = pcgmp_pkg::GRID_HEIGHT_DEF
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    pcgmp_item_if.sink                            item,
    pcgmp_result_if.source                        result,
    input  wire logic                             cfg_we,
    input  wire logic [pcgmp_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [pcgmp_pkg::FIX_W-1:0]      cfg_data
);

    localparam int DEPTH  = NUM_CHANNELS * GRID_HEIGHT * GRID_WIDTH;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CMD_W  = $bits(pcgmp_pkg::cmd_t);
    localparam int Q_W    = ADDR_W + CMD_W;

    pcgmp_pkg::back_status_t bk_stat;

    // Front to queue
    logic                push;
    logic [ADDR_W-1:0]   push_addr;
    pcgmp_pkg::cmd_t     push_cmd;

    // Queue to back
    logic [Q_W-1:0]      q_head;
    logic                q_empty;
    logic                q_full;
    logic [ADDR_W-1:0]   head_addr;
    pcgmp_pkg::cmd_t     head_cmd;

    // Projection and classification
    pcgmp_front #(
        .NUM_CHANNELS (NUM_CHANNELS),
        .GRID_WIDTH   (GRID_WIDTH),
        .GRID_HEIGHT  (GRID_HEIGHT),
        .ADDR_W       (ADDR_W)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .item      (item),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .bk_stat   (bk_stat),
        .push      (push),
        .push_addr (push_addr),
        .push_cmd  (push_cmd)
    );

    // Command queue: address in the upper bits, command below
    pcgmp_fifo #(
        .WIDTH (Q_W),
        .DEPTH (pcgmp_pkg::QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data ({push_addr, push_cmd}),
        .pop       (bk_stat.pop),
        .head      (q_head),
        .empty     (q_empty),
        .full      (q_full)
    );

    assign head_addr = q_head[Q_W-1:CMD_W];
    assign head_cmd  = pcgmp_pkg::cmd_t'(q_head[CMD_W-1:0]);

    // Store read-modify-write and result register
    pcgmp_back #(
        .NUM_CHANNELS (NUM_CHANNELS),
        .GRID_WIDTH   (GRID_WIDTH),
        .GRID_HEIGHT  (GRID_HEIGHT),
        .ADDR_W       (ADDR_W)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_empty (q_empty),
        .head_addr  (head_addr),
        .head_cmd   (head_cmd),
        .bk_stat    (bk_stat),
        .result     (result)
    );

    // ---- checks ----

    // No item is admitted while the store is being swept
    a_no_accept_in_clear: assert property (
        @(posedge clk) disable iff (!rst_n)
        bk_stat.clearing |-> !item.ready
    ) else $error("item admitted during store clear");

    // Slot reservation must keep the queue from overflowing
    a_no_push_when_full: assert property (
        @(posedge clk) disable iff (!rst_n)
        push |-> !q_full
    ) else $error("command pushed into a full queue");

    // The back never pops an empty queue
    a_no_pop_when_empty: assert property (
        @(posedge clk) disable iff (!rst_n)
        bk_stat.pop |-> !q_empty
    ) else $error("command popped from an empty queue");

    // Every fresh result traces back to a command pop through the response state
    a_result_after_pop: assert property (
        @(posedge clk) disable iff (!rst_n)
        $rose(result.valid) |-> $past(bk_stat.pop, 2)
    ) else $error("result without a matching command");

endmodule

`default_nettype wire

@@ sv/pcgmp_ram.sv @@
`default_nettype none
// ============================================================================
// pcgmp_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ============================================================================

module pcgmp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                                     clk,
    input  wire logic                                     we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                         wdata,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

@@ sv/pcgmp_fifo.sv @@
`default_nettype none
// ============================================================================
// pcgmp_fifo
// Short command queue between the projection front and the store back.
// ============================================================================

module pcgmp_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = pcgmp_pkg::QUEUE_DEPTH
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    input  wire logic [WIDTH-1:0] push_data,
    input  wire logic             pop,
    output logic      [WIDTH-1:0] head,
    output logic                  empty,
    output logic                  full
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] data_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            data_reg[wr_ptr_reg] <= push_data;
        end
    end

    assign head  = data_reg[rd_ptr_reg];
    assign empty = (count_reg == '0);
    assign full  = (count_reg == CNT_W'(DEPTH));

endmodule

`default_nettype wire

@@ sv/pcgmp_front.sv @@
`default_nettype none
// ============================================================================
// pcgmp_front
// Accept items, project points to grid cells and classify into commands.
// ============================================================================

module pcgmp_front #(
    parameter int NUM_CHANNELS = pcgmp_pkg::NUM_CHANNELS_DEF,
    parameter int GRID_WIDTH   = pcgmp_pkg::GRID_WIDTH_DEF,
    parameter int GRID_HEIGHT  = pcgmp_pkg::GRID_HEIGHT_DEF,
    parameter int ADDR_W       = 1
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    pcgmp_item_if.sink                              item,
    input  wire logic                               cfg_we,
    input  wire logic [pcgmp_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [pcgmp_pkg::FIX_W-1:0]        cfg_data,
    input  wire pcgmp_pkg::back_status_t            bk_stat,
    output logic                                    push,
    output logic [ADDR_W-1:0]                       push_addr,
    output pcgmp_pkg::cmd_t                         push_cmd
);

    localparam int FIX_W   = pcgmp_pkg::FIX_W;
    localparam int PROD_W  = pcgmp_pkg::PROD_W;
    localparam int SUM_W   = pcgmp_pkg::SUM_W;
    localparam int COORD_W = pcgmp_pkg::COORD_W;
    localparam int OCC_W   = $clog2(pcgmp_pkg::QUEUE_DEPTH + 1);

    logic [FIX_W-1:0] cfg_reg [pcgmp_pkg::NUM_REGS];

    logic             accept;
    logic [OCC_W-1:0] occ_reg, occ_next;

    logic                    v1_reg, v2_reg, v3_reg, v4_reg;
    pcgmp_pkg::item_info_t   info1_reg, info2_reg, info3_reg, info4_reg;
    pcgmp_pkg::item_info_t   info_in;

    logic signed [PROD_W-1:0] pc0_reg, pc1_reg, pc2_reg;
    logic signed [PROD_W-1:0] pr0_reg, pr1_reg, pr2_reg;
    logic signed [PROD_W-1:0] pc0_next, pc1_next, pc2_next;
    logic signed [PROD_W-1:0] pr0_next, pr1_next, pr2_next;

    logic signed [SUM_W-1:0] ca_reg, cb_reg, ra_reg, rb_reg;
    logic signed [SUM_W-1:0] off_col, off_row;
    logic signed [SUM_W-1:0] csum_reg, rsum_reg;
    logic [COORD_W-1:0]      ccoord_reg, rcoord_reg, ccoord_next, rcoord_next;

    logic                    col_ok, row_ok, rd_ok;
    logic [ADDR_W-1:0]       sel_col, sel_row;

    // ---- configuration ----
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < pcgmp_pkg::NUM_REGS; i++)
            begin
                cfg_reg[i] <= '0;
            end
        end
        else if (cfg_we)
        begin
            cfg_reg[cfg_index] <= cfg_data;
        end
    end

    // ---- admission: ready only outside the sweep and while a queue slot is free ----
    assign item.ready = !bk_stat.clearing && (occ_reg < OCC_W'(pcgmp_pkg::QUEUE_DEPTH));
    assign accept     = item.valid && item.ready;

    always_comb
    begin
        occ_next = occ_reg;
        if (accept && !bk_stat.pop)
        begin
            occ_next = occ_reg + 1'b1;
        end
        else if (bk_stat.pop && !accept)
        begin
            occ_next = occ_reg - 1'b1;
        end
    end

    // ---- stage 1: products ----
    always_comb
    begin
        info_in.op       = pcgmp_pkg::op_t'(item.operation);
        info_in.ch_bad   = ({1'b0, item.channel} >= (pcgmp_pkg::CHAN_W + 1)'(NUM_CHANNELS));
        info_in.channel  = item.channel;
        info_in.score    = item.score;
        info_in.read_col = item.read_col;
        info_in.read_row = item.read_row;

        pc0_next = $signed(cfg_reg[pcgmp_pkg::REG_ROW_X_COEF_X]) * item.point_x;
        pc1_next = $signed(cfg_reg[pcgmp_pkg::REG_ROW_X_COEF_Y]) * item.point_y;
        pc2_next = $signed(cfg_reg[pcgmp_pkg::REG_ROW_X_COEF_Z]) * item.point_z;
        pr0_next = $signed(cfg_reg[pcgmp_pkg::REG_ROW_Y_COEF_X]) * item.point_x;
        pr1_next = $signed(cfg_reg[pcgmp_pkg::REG_ROW_Y_COEF_Y]) * item.point_y;
        pr2_next = $signed(cfg_reg[pcgmp_pkg::REG_ROW_Y_COEF_Z]) * item.point_z;
    end

    // Offsets are cells in Q16.16; move them to the Q32.32 of the products
    assign off_col = {{(SUM_W - FIX_W - 16){cfg_reg[pcgmp_pkg::REG_ROW_X_OFFSET][FIX_W-1]}},
                      cfg_reg[pcgmp_pkg::REG_ROW_X_OFFSET], 16'b0};
    assign off_row = {{(SUM_W - FIX_W - 16){cfg_reg[pcgmp_pkg::REG_ROW_Y_OFFSET][FIX_W-1]}},
                      cfg_reg[pcgmp_pkg::REG_ROW_Y_OFFSET], 16'b0};

    // ---- stage 4 input: truncate toward zero ----
    always_comb
    begin
        ccoord_next = csum_reg[SUM_W-1:FIX_W]
                    + COORD_W'(csum_reg[SUM_W-1] && (|csum_reg[FIX_W-1:0]));
        rcoord_next = rsum_reg[SUM_W-1:FIX_W]
                    + COORD_W'(rsum_reg[SUM_W-1] && (|rsum_reg[FIX_W-1:0]));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            occ_reg <= '0;
            v1_reg  <= 1'b0;
            v2_reg  <= 1'b0;
            v3_reg  <= 1'b0;
            v4_reg  <= 1'b0;
        end
        else
        begin
            occ_reg <= occ_next;
            v1_reg  <= accept;
            v2_reg  <= v1_reg;
            v3_reg  <= v2_reg;
            v4_reg  <= v3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        info1_reg  <= info_in;
        pc0_reg    <= pc0_next;
        pc1_reg    <= pc1_next;
        pc2_reg    <= pc2_next;
        pr0_reg    <= pr0_next;
        pr1_reg    <= pr1_next;
        pr2_reg    <= pr2_next;

        info2_reg  <= info1_reg;
        ca_reg     <= SUM_W'(pc0_reg) + SUM_W'(pc1_reg);
        cb_reg     <= SUM_W'(pc2_reg) + off_col;
        ra_reg     <= SUM_W'(pr0_reg) + SUM_W'(pr1_reg);
        rb_reg     <= SUM_W'(pr2_reg) + off_row;

        info3_reg  <= info2_reg;
        csum_reg   <= ca_reg + cb_reg;
        rsum_reg   <= ra_reg + rb_reg;

        info4_reg  <= info3_reg;
        ccoord_reg <= ccoord_next;
        rcoord_reg <= rcoord_next;
    end

    // ---- classify and form the store address ----
    assign col_ok = !ccoord_reg[COORD_W-1] && (ccoord_reg < COORD_W'(GRID_WIDTH));
    assign row_ok = !rcoord_reg[COORD_W-1] && (rcoord_reg < COORD_W'(GRID_HEIGHT));
    assign rd_ok  = (32'(info4_reg.read_col) < 32'(GRID_WIDTH))
                 && (32'(info4_reg.read_row) < 32'(GRID_HEIGHT));

    always_comb
    begin
        push_cmd.score = info4_reg.score;
        push_cmd.col   = '0;
        push_cmd.row   = '0;
        sel_col        = ADDR_W'(ccoord_reg);
        sel_row        = ADDR_W'(rcoord_reg);
        if (info4_reg.ch_bad)
        begin
            push_cmd.kind = pcgmp_pkg::CMD_BAD_CHANNEL;
        end
        else if (info4_reg.op == pcgmp_pkg::OP_READ)
        begin
            sel_col = ADDR_W'(info4_reg.read_col);
            sel_row = ADDR_W'(info4_reg.read_row);
            if (rd_ok)
            begin
                push_cmd.kind = pcgmp_pkg::CMD_READ;
                push_cmd.col  = info4_reg.read_col;
                push_cmd.row  = info4_reg.read_row;
            end
            else
            begin
                push_cmd.kind = pcgmp_pkg::CMD_OUTSIDE;
            end
        end
        else if (col_ok && row_ok)
        begin
            push_cmd.kind = pcgmp_pkg::CMD_INSERT;
            push_cmd.col  = pcgmp_pkg::FCOORD_W'(ccoord_reg);
            push_cmd.row  = pcgmp_pkg::FCOORD_W'(rcoord_reg);
        end
        else
        begin
            push_cmd.kind = pcgmp_pkg::CMD_OUTSIDE;
        end
    end

    assign push_addr = (ADDR_W'(info4_reg.channel) * ADDR_W'(GRID_HEIGHT) + sel_row)
                       * ADDR_W'(GRID_WIDTH) + sel_col;
    assign push      = v4_reg;

endmodule

`default_nettype wire

@@ sv/pcgmp_back.sv @@
`default_nettype none
// ============================================================================
// pcgmp_back
// Execute commands on the confidence store and register the results.
// ============================================================================

module pcgmp_back #(
    parameter int NUM_CHANNELS = pcgmp_pkg::NUM_CHANNELS_DEF,
    parameter int GRID_WIDTH   = pcgmp_pkg::GRID_WIDTH_DEF,
    parameter int GRID_HEIGHT  = pcgmp_pkg::GRID_HEIGHT_DEF,
    parameter int ADDR_W       = 1
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       head_empty,
    input  wire logic [ADDR_W-1:0]          head_addr,
    input  wire pcgmp_pkg::cmd_t            head_cmd,
    output pcgmp_pkg::back_status_t         bk_stat,
    pcgmp_result_if.source                  result
);

    localparam int DEPTH = NUM_CHANNELS * GRID_HEIGHT * GRID_WIDTH;
    localparam int SW    = pcgmp_pkg::SCORE_W;

    pcgmp_pkg::bk_state_t state_reg, state_next;

    logic [ADDR_W-1:0]   clr_addr_reg, clr_addr_next;
    logic [ADDR_W-1:0]   addr_reg, addr_next;
    pcgmp_pkg::cmd_t     cmd_reg, cmd_next;

    logic                out_valid_reg, out_valid_next;
    pcgmp_pkg::status_t  status_reg, status_next;
    logic [pcgmp_pkg::FCOORD_W-1:0] col_reg, col_next, row_reg, row_next;
    logic [pcgmp_pkg::PCT_W-1:0]    pct_reg, pct_next;

    logic                take;
    logic                load;
    logic                pop;
    logic                ram_we;
    logic [ADDR_W-1:0]   ram_waddr;
    logic [SW-1:0]       ram_wdata;
    logic [SW-1:0]       ram_rdata;

    pcgmp_ram #(
        .WIDTH (SW),
        .DEPTH (DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (head_addr),
        .rdata (ram_rdata)
    );

    // Take a command only when the result register will be free for it
    assign take = !head_empty && (!out_valid_reg || result.ready);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            pcgmp_pkg::BK_CLEAR:
            begin
                if (clr_addr_reg == ADDR_W'(DEPTH - 1))
                begin
                    state_next = pcgmp_pkg::BK_IDLE;
                end
            end
            pcgmp_pkg::BK_IDLE:
            begin
                if (take)
                begin
                    state_next = pcgmp_pkg::BK_RESP;
                end
            end
            pcgmp_pkg::BK_RESP:
            begin
                state_next = pcgmp_pkg::BK_IDLE;
            end
            default:
            begin
                state_next = pcgmp_pkg::BK_CLEAR;
            end
        endcase
    end

    always_comb
    begin
        ram_we        = 1'b0;
        ram_waddr     = addr_reg;
        ram_wdata     = cmd_reg.score;
        pop           = 1'b0;
        load          = 1'b0;
        clr_addr_next = clr_addr_reg;
        addr_next     = addr_reg;
        cmd_next      = cmd_reg;
        status_next   = pcgmp_pkg::ST_BAD_CHANNEL;
        col_next      = '0;
        row_next      = '0;
        pct_next      = '0;
        case (state_reg)
            pcgmp_pkg::BK_CLEAR:
            begin
                ram_we        = 1'b1;
                ram_waddr     = clr_addr_reg;
                ram_wdata     = '0;
                clr_addr_next = clr_addr_reg + 1'b1;
            end
            pcgmp_pkg::BK_IDLE:
            begin
                if (take)
                begin
                    pop       = 1'b1;
                    addr_next = head_addr;
                    cmd_next  = head_cmd;
                end
            end
            pcgmp_pkg::BK_RESP:
            begin
                load = 1'b1;
                case (cmd_reg.kind)
                    pcgmp_pkg::CMD_READ:
                    begin
                        status_next = pcgmp_pkg::ST_READ_DONE;
                        col_next    = cmd_reg.col;
                        row_next    = cmd_reg.row;
                        pct_next    = pcgmp_pkg::percent_of(ram_rdata);
                    end
                    pcgmp_pkg::CMD_INSERT:
                    begin
                        col_next = cmd_reg.col;
                        row_next = cmd_reg.row;
                        if (cmd_reg.score > ram_rdata)
                        begin
                            ram_we      = 1'b1;
                            status_next = pcgmp_pkg::ST_RAISED;
                        end
                        else
                        begin
                            status_next = pcgmp_pkg::ST_KEPT;
                        end
                    end
                    pcgmp_pkg::CMD_OUTSIDE:
                    begin
                        status_next = pcgmp_pkg::ST_OUTSIDE;
                    end
                    default:
                    begin
                        status_next = pcgmp_pkg::ST_BAD_CHANNEL;
                    end
                endcase
            end
            default:
            begin
                ram_we = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (load)
        begin
            out_valid_next = 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= pcgmp_pkg::BK_CLEAR;
            clr_addr_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_addr_reg  <= clr_addr_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        addr_reg <= addr_next;
        cmd_reg  <= cmd_next;
        if (load)
        begin
            status_reg <= status_next;
            col_reg    <= col_next;
            row_reg    <= row_next;
            pct_reg    <= pct_next;
        end
    end

    assign bk_stat.clearing = (state_reg == pcgmp_pkg::BK_CLEAR);
    assign bk_stat.pop      = pop;

    assign result.valid    = out_valid_reg;
    assign result.status   = status_reg;
    assign result.cell_col = col_reg;
    assign result.cell_row = row_reg;
    assign result.percent  = pct_reg;

endmodule

`default_nettype wire
